// ===== rtl/scy_pkg.sv =====
// shared constants, codes and handshake structs for the scytale transposition block
`default_nettype none
package scy_pkg;

  // message store capacity in bytes
  localparam int MAX_LEN = 64;
  // store address width and byte count width (count reaches MAX_LEN)
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  // rows register width, also the width of the walk arithmetic
  localparam int ROWS_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = ROWS_W;
  localparam int IDX_W   = 1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [IDX_W-1:0] REG_MODE = 1'd1;

  // cipher direction
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // top level sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } state_t;

  // sequencer to walker controls
  typedef struct packed {
    logic start;
    logic div_en;
    logic step;
  } walk_ctl_t;

  // walker to sequencer status
  typedef struct packed {
    logic              div_done;
    logic [ADDR_W-1:0] addr;
  } walk_stat_t;

endpackage
`default_nettype wire

// ===== rtl/scy_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module scy_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/scy_walker.sv =====
// grid walker: divides length by rows, then steps the store read address
`default_nettype none
module scy_walker (
  input  wire logic                      clk,
  input  wire scy_pkg::walk_ctl_t        ctl,
  input  wire logic [scy_pkg::ROWS_W-1:0] len,
  input  wire logic [scy_pkg::ROWS_W-1:0] nrows,
  input  wire logic                      mode,
  output scy_pkg::walk_stat_t            stat
);

  localparam int W = scy_pkg::ROWS_W;

  logic [W-1:0] len_q;
  logic [W-1:0] nrows_q;
  logic         mode_q;
  logic [W-1:0] rem;
  logic [W-1:0] quo;
  logic [W-1:0] idx;
  logic [W-1:0] row;
  logic [W-1:0] base;
  logic [W-1:0] col;
  logic [W-1:0] cells;
  logic [W-1:0] op_a;
  logic [W-1:0] op_b;
  logic         op_sub;
  logic [W:0]   sum;
  logic [W-1:0] dec_addr;

  // cells in the current row: rows below the remainder hold one more
  assign cells = (row < rem) ? quo + W'(1) : quo;

  // shared add/subtract unit
  always_comb begin
    op_a   = idx;
    op_b   = nrows_q;
    op_sub = 1'b0;
    if (ctl.div_en) begin
      op_a   = rem;
      op_b   = nrows_q;
      op_sub = 1'b1;
    end else if (mode_q == scy_pkg::MODE_DEC) begin
      op_a = base;
      op_b = cells;
    end
  end

  assign sum = op_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});

  // borrow out means the remainder is below the row count
  assign stat.div_done = sum[W];

  // read address: position order for encrypt, rank for decrypt
  assign dec_addr  = base + col;
  assign stat.addr = (mode_q == scy_pkg::MODE_DEC) ? dec_addr[scy_pkg::ADDR_W-1:0]
                                                   : idx[scy_pkg::ADDR_W-1:0];

  // divide by repeated subtraction, then walk the grid one cell a request
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      len_q   <= len;
      nrows_q <= nrows;
      mode_q  <= mode;
      rem     <= len;
      quo     <= '0;
      idx     <= '0;
      row     <= '0;
      base    <= '0;
      col     <= '0;
    end else if (ctl.div_en) begin
      if (!sum[W]) begin
        rem <= sum[W-1:0];
        quo <= quo + W'(1);
      end
    end else if (ctl.step) begin
      if (mode_q == scy_pkg::MODE_DEC) begin
        if (row == nrows_q - W'(1)) begin
          row  <= '0;
          base <= '0;
          col  <= col + W'(1);
        end else begin
          row  <= row + W'(1);
          base <= sum[W-1:0];
        end
      end else begin
        if (sum < {1'b0, len_q}) begin
          idx <= sum[W-1:0];
        end else begin
          row <= row + W'(1);
          idx <= row + W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/scytale_transposition.sv =====
// Scytale transposition top level: load sequencer, message store and walker.
// Bytes load first. After the last byte the row division runs, then each result
// passes a store read state and a show state that waits for out_ready.
// Reset (rst, synchronous) returns to loading with rows=1, mode=0, count and
// drop flag cleared; overflow and the message store are not cleared.
`default_nettype none
module scytale_transposition (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [scy_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [scy_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [scy_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic                         last_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [scy_pkg::BYTE_W-1:0]   out_byte,
  output logic                              last_out,
  output logic                              overflow
);

  localparam int CW = scy_pkg::CNT_W;
  localparam int RW = scy_pkg::ROWS_W;

  scy_pkg::state_t     state;
  scy_pkg::state_t     state_next;
  scy_pkg::walk_ctl_t  wctl;
  scy_pkg::walk_stat_t wstat;

  logic [RW-1:0] rows;
  logic          mode;
  logic [CW-1:0] count;
  logic          dropped;
  logic [CW-1:0] msg_len;
  logic          ovf;
  logic [CW-1:0] out_cnt;
  logic          in_acc;
  logic          out_acc;
  logic          has_room;
  logic [CW-1:0] len_cur;
  logic [RW-1:0] nrows_cur;
  logic          ram_re;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign has_room  = count < CW'(scy_pkg::MAX_LEN);
  assign len_cur   = has_room ? count + CW'(1) : count;
  assign nrows_cur = (rows == '0) ? RW'(1) : rows;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= RW'(1);
      mode <= scy_pkg::MODE_ENC;
    end else if (cfg_write) begin
      unique case (cfg_index)
        scy_pkg::REG_ROWS: rows <= cfg_data[RW-1:0];
        scy_pkg::REG_MODE: mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scy_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      scy_pkg::ST_LOAD: begin
        if (in_acc && last_in) begin
          state_next = scy_pkg::ST_DIV;
        end
      end
      scy_pkg::ST_DIV: begin
        if (wstat.div_done) begin
          state_next = scy_pkg::ST_READ;
        end
      end
      scy_pkg::ST_READ: begin
        state_next = scy_pkg::ST_SHOW;
      end
      scy_pkg::ST_SHOW: begin
        if (out_ready) begin
          state_next = last_out ? scy_pkg::ST_LOAD : scy_pkg::ST_READ;
        end
      end
      default: state_next = scy_pkg::ST_LOAD;
    endcase
  end

  // state outputs and walker controls
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ram_re      = 1'b0;
    wctl        = '0;
    unique case (state)
      scy_pkg::ST_LOAD: begin
        in_ready   = 1'b1;
        wctl.start = in_valid && last_in;
      end
      scy_pkg::ST_DIV:  wctl.div_en = 1'b1;
      scy_pkg::ST_READ: ram_re      = 1'b1;
      scy_pkg::ST_SHOW: begin
        out_valid = 1'b1;
        wctl.step = out_ready;
      end
      default: ;
    endcase
  end

  // byte count, drop flag and result counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      out_cnt <= '0;
    end else begin
      if (in_acc) begin
        if (last_in) begin
          count   <= '0;
          dropped <= 1'b0;
        end else if (has_room) begin
          count <= count + CW'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (wctl.start) begin
        out_cnt <= '0;
      end else if (out_acc) begin
        out_cnt <= out_cnt + CW'(1);
      end
    end
  end

  // message length and overflow for the result burst
  always_ff @(posedge clk) begin
    if (wctl.start) begin
      msg_len <= len_cur;
      ovf     <= dropped || !has_room;
    end
  end

  assign last_out = (out_cnt == msg_len - CW'(1));
  assign overflow = ovf;

  // message store
  scy_ram #(
    .WIDTH (scy_pkg::BYTE_W),
    .DEPTH (scy_pkg::MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (in_acc && has_room),
    .waddr (count[scy_pkg::ADDR_W-1:0]),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (wstat.addr),
    .rdata (out_byte)
  );

  // division and address walk
  scy_walker u_walker (
    .clk   (clk),
    .ctl   (wctl),
    .len   (RW'(len_cur)),
    .nrows (nrows_cur),
    .mode  (mode),
    .stat  (wstat)
  );

endmodule
`default_nettype wire

// ===== rtl/scy_checker.sv =====
// port-level checker for the scytale transposition block, bound to the top level
`default_nettype none
module scy_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       last_in,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [scy_pkg::BYTE_W-1:0] out_byte,
  input wire logic                       last_out,
  input wire logic                       overflow
);

  // loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // a byte that does not end the message keeps the block loading
  a_keep_loading: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last_in) |=> in_ready)
    else $error("block left loading before the last byte");

  // after the final result the block returns to loading
  a_end_of_burst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_out) |=> (!out_valid && in_ready))
    else $error("no return to loading after final result");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(last_out) && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind scytale_transposition scy_checker u_scy_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for scytale_transposition: random messages checked byte by byte against a local model
`timescale 1ns / 100ps
module tb_top;
  import scy_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int TARGET_BYTES  = 370;

  // one queued request: either a message byte or a register write
  typedef struct {
    bit                is_cfg;
    logic [IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]  reg_val;
    logic [BYTE_W-1:0] data;
    logic              last;
  } load_req_t;

  // one transposed output byte with its flags
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              ovf;
  } cipher_byte_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_write = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              last_in   = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              last_out;
  logic              overflow;

  load_req_t    load_queue[$];
  cipher_byte_t cipher_queue[$];

  // model copy of the message store and registers
  logic [BYTE_W-1:0] msg_buf [MAX_LEN];
  int                msg_len     = 0;
  bit                msg_dropped = 1'b0;
  logic [ROWS_W-1:0] key_rows    = 7'd1;
  logic              key_mode    = MODE_ENC;

  int n_queued        = 0;
  int n_loaded        = 0;
  int n_messages      = 0;
  int n_overflow_msgs = 0;
  int n_checked       = 0;
  int n_errors        = 0;

  // sender and receiver pacing
  int gap_left    = 0;
  int settle_left = SETTLE_CYCLES;
  bit tx_calm     = 1'b0;
  int stall_left  = 0;
  bit rx_calm     = 1'b0;

  // long receiver hold-off
  logic hold_on     = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;
  int   busy_cycles = 0;

  scytale_transposition DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_out  (last_out),
    .overflow  (overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // store one accepted byte; on the last one queue the transposed message
  task automatic transpose_on_last(input logic [BYTE_W-1:0] val, input logic last);
    int                nrows;
    int                ncols;
    int                k;
    int                idx;
    int                r;
    int                c;
    int                rank [MAX_LEN];
    logic [BYTE_W-1:0] grid_out [MAX_LEN];
    n_loaded++;
    if (msg_len < MAX_LEN) begin
      msg_buf[msg_len] = val;
      msg_len++;
    end else begin
      msg_dropped = 1'b1;
    end
    if (last) begin
      // zero rows behaves as one row
      nrows = (key_rows == 0) ? 1 : int'(key_rows);
      ncols = (msg_len + nrows - 1) / nrows;
      // rank of each position in row-by-row reading order
      k = 0;
      for (r = 0; r < nrows; r++) begin
        for (c = 0; c < ncols; c++) begin
          idx = c * nrows + r;
          if (idx < msg_len) begin
            rank[idx] = k;
            k++;
          end
        end
      end
      for (idx = 0; idx < msg_len; idx++) begin
        if (key_mode == MODE_ENC) grid_out[rank[idx]] = msg_buf[idx];
        else grid_out[idx] = msg_buf[rank[idx]];
      end
      for (idx = 0; idx < msg_len; idx++) begin
        cipher_queue.push_back('{grid_out[idx], idx == msg_len - 1, msg_dropped});
      end
      n_messages++;
      if (msg_dropped) n_overflow_msgs++;
      msg_len     = 0;
      msg_dropped = 1'b0;
    end
  endtask

  task automatic push_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    load_req_t req;
    req = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, data: '0, last: 1'b0};
    load_queue.push_back(req);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] val, input logic last);
    load_req_t req;
    req = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, data: val, last: last};
    load_queue.push_back(req);
    n_queued++;
  endtask

  task automatic push_message(input int len);
    for (int i = 0; i < len; i++) push_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1);
  endtask

  // request driver: bytes with random gaps, register writes only when idle
  always @(posedge clk) begin : drive_proc
    bit        nxt_valid;
    bit        nxt_we;
    load_req_t req;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_we    = 1'b0;
      if (in_valid && in_ready) begin
        transpose_on_last(data_byte, last_in);
        nxt_valid = 1'b0;
      end
      if (cipher_queue.size() != 0) settle_left = SETTLE_CYCLES;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (load_queue.size() != 0) begin
          req = load_queue[0];
          if (!req.is_cfg) begin
            req = load_queue.pop_front();
            data_byte <= req.data;
            last_in   <= req.last;
            nxt_valid = 1'b1;
            if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
            gap_left = tx_calm ? 0 : $urandom_range(0, 8);
          end else if (cipher_queue.size() == 0 && msg_len == 0) begin
            // let the block drain before touching its registers
            if (settle_left > 0) begin
              settle_left--;
            end else begin
              req = load_queue.pop_front();
              cfg_index <= req.reg_idx;
              cfg_data  <= req.reg_val;
              nxt_we = 1'b1;
              if (req.reg_idx == REG_ROWS) key_rows = req.reg_val;
              else key_mode = req.reg_val[0];
            end
          end
        end
      end
      in_valid  <= nxt_valid;
      cfg_write <= nxt_we;
    end
  end

  // result monitor with random stalls
  always @(posedge clk) begin : check_proc
    cipher_byte_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (cipher_queue.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("tb_top: unexpected output byte %02h last %0b overflow %0b",
                     out_byte, last_out, overflow);
        end else begin
          want = cipher_queue.pop_front();
          if (want !== {out_byte, last_out, overflow}) begin
            n_errors++;
            if (n_errors <= 10)
              $display("tb_top: output %0d expected byte %02h last %0b overflow %0b,",
                       n_checked, want.data, want.last, want.ovf,
                       " got byte %02h last %0b overflow %0b",
                       out_byte, last_out, overflow);
          end
        end
        if ($urandom_range(0, 23) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 8);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0) && !hold_on;
    end
  end

  // one long hold-off while the block is emitting, so input backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_on     <= 1'b0;
      hold_done   <= 1'b0;
      hold_left   <= 0;
      busy_cycles <= 0;
    end else if (hold_on) begin
      if (hold_left == 1) begin
        hold_on   <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_left <= hold_left - 1;
    end else if (!hold_done && out_valid) begin
      if (busy_cycles == 200) begin
        hold_on   <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end
      busy_cycles <= busy_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin : stim_proc
    int               len;
    int               msg_no;
    logic [CFG_W-1:0] rows_val;
    // directed: identity key, extreme bytes, zero rows, short rows, oversized key
    push_cfg(REG_ROWS, CFG_W'(1));
    push_cfg(REG_MODE, CFG_W'(MODE_ENC));
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b1);
    push_cfg(REG_ROWS, CFG_W'(0));
    push_message(3);
    push_cfg(REG_ROWS, CFG_W'(3));
    push_cfg(REG_MODE, CFG_W'(MODE_DEC));
    push_message(7);
    push_cfg(REG_MODE, CFG_W'(MODE_ENC));
    push_message(7);
    push_cfg(REG_ROWS, CFG_W'(127));
    push_message(4);

    // random messages, mostly short, a few at or beyond capacity
    msg_no = 0;
    while (n_queued < TARGET_BYTES) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       rows_val = '0;
          1:       rows_val = CFG_W'($urandom_range(MAX_LEN + 1, 127));
          2:       rows_val = CFG_W'(MAX_LEN);
          default: rows_val = CFG_W'($urandom_range(1, 8));
        endcase
        push_cfg(REG_ROWS, rows_val);
      end
      if ($urandom_range(0, 3) == 0) push_cfg(REG_MODE, CFG_W'($urandom_range(0, 1)));
      if (msg_no == 2) len = MAX_LEN;
      else if (msg_no == 5) len = MAX_LEN + 2;
      else if ($urandom_range(0, 11) == 0) len = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
      else len = $urandom_range(1, 12);
      push_message(len);
      msg_no++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (load_queue.size() == 0 && !in_valid);
    wait (cipher_queue.size() == 0);
    repeat (80) @(posedge clk);

    $display("tb_top: %0d messages (%0d over capacity), %0d bytes loaded,",
             n_messages, n_overflow_msgs, n_loaded,
             " %0d output bytes checked", n_checked);
    if (n_errors == 0 && cipher_queue.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: %0d errors", n_errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2400000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
